// ----- hw/rtl/bsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_pkg
// Word types and fixed widths shared by the byte stream reassembler.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned INDEX_W  = 32;
    localparam int unsigned UNASM_W  = 7;

    typedef struct packed {
        logic [BYTE_W-1:0]  byte_value;
        logic [INDEX_W-1:0] stream_index;
        logic               has_byte;
        logic               last_of_segment;
        logic               eof;
    } seg_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               is_data;
        logic               stream_end;
        logic               last_of_run;
        logic [UNASM_W-1:0] unassembled_count;
        logic               is_empty;
    } res_word_t;

endpackage

// ----- hw/rtl/byte_stream_reassembler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_reassembler_unit
// Reorders segment bytes into the in-order stream through a byte ring.
// ----------------------------------------------------------------------------
// A segment word that is not the last of its segment is taken back to back
// with the next. The last word of a segment is taken and followed by the
// fetch state and then by the drain of the ready bytes in order; when nothing
// is ready, the status-only result leaves from the fetch state itself.
// seg_stall is high meanwhile, and a stalled result register stretches it. The
// fetch state covers the registered read data of the byte ring, whose
// read port is then kept one byte ahead of the result register. A result
// waiting in the result register does not block segment words that are not
// the last of their segment.
module byte_stream_reassembler_unit #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seg_valid,
    output logic                seg_stall,
    input  bsr_pkg::seg_word_t  seg_word,
    output logic                res_valid,
    input  logic                res_stall,
    output bsr_pkg::res_word_t  res_word
);
    import bsr_pkg::*;

    localparam int unsigned SLOT_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(CAPACITY - 1);
    localparam logic [SLOT_W:0]    CAP_EXT   = (SLOT_W + 1)'(CAPACITY);
    localparam logic [INDEX_W-1:0] CAP_IDX   = INDEX_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EMIT
    } state_t;

    state_t              state_reg,      state_next;
    logic [CAPACITY-1:0] marks_reg,      marks_next;
    logic [INDEX_W-1:0]  next_index_reg, next_index_next;
    logic [SLOT_W-1:0]   next_slot_reg,  next_slot_next;
    logic [INDEX_W-1:0]  end_index_reg,  end_index_next;
    logic                end_seen_reg,   end_seen_next;
    logic [CNT_W-1:0]    count_reg,      count_next;
    logic                res_valid_reg,  res_valid_next;
    res_word_t           res_word_reg,   res_word_next;

    logic                seg_take;
    logic                res_free;
    logic [INDEX_W-1:0]  offset;
    logic                in_window;
    logic [SLOT_W:0]     slot_sum;
    logic [SLOT_W-1:0]   wr_slot;
    logic                wr_en;
    logic [SLOT_W-1:0]   slot_inc;
    logic                more;
    logic                emit;
    logic [SLOT_W-1:0]   rd_addr;
    logic [BYTE_W-1:0]   rd_data;

    assign seg_stall = (state_reg != S_IDLE);
    assign seg_take  = seg_valid && !seg_stall;
    assign res_free  = !res_valid_reg || !res_stall;

    // Map an in-window index onto its ring slot relative to the head slot.
    assign offset    = seg_word.stream_index - next_index_reg;
    assign in_window = seg_word.has_byte && (seg_word.stream_index >= next_index_reg)
                       && (offset < CAP_IDX);
    assign slot_sum  = {1'b0, next_slot_reg} + {1'b0, offset[SLOT_W-1:0]};
    assign wr_slot   = (slot_sum >= CAP_EXT) ? SLOT_W'(slot_sum - CAP_EXT)
                                             : slot_sum[SLOT_W-1:0];
    assign wr_en     = seg_take && in_window;

    // Head slot after one advance; the index wrap restarts the slot at zero.
    always_comb
    begin
        if (next_index_reg == '1 || next_slot_reg == LAST_SLOT)
        begin
            slot_inc = '0;
        end
        else
        begin
            slot_inc = next_slot_reg + SLOT_W'(1);
        end
    end

    assign emit    = (state_reg == S_EMIT) && res_free;
    assign more    = marks_reg[slot_inc] && (slot_inc != next_slot_reg);
    // Keep the read port one byte ahead while draining.
    assign rd_addr = emit ? slot_inc : next_slot_reg;

    bsr_ring #(
        .DEPTH (CAPACITY)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_slot),
        .wr_data (seg_word.byte_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        marks_next      = marks_reg;
        next_index_next = next_index_reg;
        next_slot_next  = next_slot_reg;
        end_index_next  = end_index_reg;
        end_seen_next   = end_seen_reg;
        count_next      = count_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_word_next   = res_word_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (seg_take)
                begin
                    if (seg_word.eof)
                    begin
                        end_seen_next  = 1'b1;
                        end_index_next = seg_word.stream_index
                                         + INDEX_W'(seg_word.has_byte);
                    end
                    if (in_window && !marks_reg[wr_slot])
                    begin
                        marks_next[wr_slot] = 1'b1;
                        count_next          = count_reg + CNT_W'(1);
                    end
                    if (seg_word.last_of_segment)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                if (marks_reg[next_slot_reg])
                begin
                    state_next = S_EMIT;
                end
                else if (res_free)
                begin
                    res_valid_next                  = 1'b1;
                    res_word_next.out_byte          = '0;
                    res_word_next.is_data           = 1'b0;
                    res_word_next.stream_end        = end_seen_reg
                                                      && (next_index_reg == end_index_reg);
                    res_word_next.last_of_run       = 1'b1;
                    res_word_next.unassembled_count = UNASM_W'(count_reg);
                    res_word_next.is_empty          = (count_reg == '0);
                    state_next                      = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    marks_next[next_slot_reg] = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    next_index_next                 = next_index_reg + INDEX_W'(1);
                    next_slot_next                  = slot_inc;
                    res_valid_next                  = 1'b1;
                    res_word_next.out_byte          = rd_data;
                    res_word_next.is_data           = 1'b1;
                    res_word_next.stream_end        = end_seen_reg
                                                      && (next_index_next == end_index_reg);
                    res_word_next.last_of_run       = !more;
                    res_word_next.unassembled_count = UNASM_W'(count_next);
                    res_word_next.is_empty          = (count_next == '0);
                    if (!more)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            marks_reg      <= '0;
            next_index_reg <= '0;
            next_slot_reg  <= '0;
            end_index_reg  <= '0;
            end_seen_reg   <= 1'b0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            marks_reg      <= marks_next;
            next_index_reg <= next_index_next;
            next_slot_reg  <= next_slot_next;
            end_index_reg  <= end_index_next;
            end_seen_reg   <= end_seen_next;
            count_reg      <= count_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_word_reg <= res_word_next;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

`ifndef ASSERT_OFF
    a_count_matches_marks: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(marks_reg)))
        else $error("stored count differs from the number of present marks");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_word.is_data) |-> res_word.last_of_run)
        else $error("status-only result not marked last of run");

    a_more_means_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.is_data && !res_word.last_of_run) |-> !res_word.is_empty)
        else $error("run continues with nothing stored");
`endif

endmodule

// ----- hw/rtl/bsr_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_ring
// Byte ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsr_ring #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [bsr_pkg::BYTE_W-1:0] wr_data,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [bsr_pkg::BYTE_W-1:0] rd_data
);
    import bsr_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
